>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_HOLDS(label, clk, rst, !(expr))

`endif

>>> design/dtas_pkg.sv
// types, constants and calendar functions of the datetime add seconds core
`timescale 1ns / 1ps

package dtas_pkg;

   localparam int DELTA_WIDTH_DEF = 24;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } dtas_date_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } dtas_result_type;

   // divider request: start pulse and divisor select
   typedef struct packed {
      logic start;
      logic by_24;
   } dtas_div_ctl_type;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]   BAD_MONTH_DAYS = 5'd30;
   localparam logic [DAY_W-1:0]   FEB_DAYS = 5'd28;
   localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;

   localparam logic [6:0] DIVISOR_60 = 7'd60;
   localparam logic [6:0] DIVISOR_24 = 7'd24;

   localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // year / 25 by reciprocal, exact for every 14 bit year
   localparam int LEAP_SHIFT = 20;
   localparam logic [15:0] RECIP_25 = 16'(((1 << LEAP_SHIFT) + 24) / 25);

   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [29:0] prod;
      logic [9:0]  quo;
      logic [YEAR_W-1:0] quo_x25;
      logic div25;
      prod    = 30'(year) * 30'(RECIP_25);
      quo     = prod[29:LEAP_SHIFT];
      quo_x25 = YEAR_W'({4'b0, quo} * 14'd25);
      div25   = (quo_x25 == year);
      return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
   endfunction

   // days in a month, invalid months count as 30
   function automatic logic [DAY_W-1:0] days_of(input logic [YEAR_W-1:0] year,
                                                input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      if (month < MONTH_JAN || month > MONTH_DEC) begin
         len = BAD_MONTH_DAYS;
      end else if (month == MONTH_FEB) begin
         len = is_leap(year) ? FEB_LEAP_DAYS : FEB_DAYS;
      end else begin
         len = MONTH_DAYS[month - MONTH_JAN];
      end
      return len;
   endfunction

endpackage

>>> design/dtas_ifs.sv
// request and response channel interfaces of the datetime add seconds core
`timescale 1ns / 1ps

interface dtas_req_if #(parameter int DELTA_WIDTH = dtas_pkg::DELTA_WIDTH_DEF) ();
   logic valid;
   logic ready;
   logic [dtas_pkg::YEAR_W-1:0]   year_in;
   logic [dtas_pkg::MONTH_W-1:0]  month_in;
   logic [dtas_pkg::DAY_W-1:0]    day_in;
   logic [dtas_pkg::HOUR_W-1:0]   hour_in;
   logic [dtas_pkg::MINUTE_W-1:0] minute_in;
   logic [dtas_pkg::SECOND_W-1:0] second_in;
   logic signed [DELTA_WIDTH-1:0] delta_seconds;

   modport source (output valid, year_in, month_in, day_in, hour_in, minute_in,
                   second_in, delta_seconds, input ready);
   modport sink (input valid, year_in, month_in, day_in, hour_in, minute_in,
                 second_in, delta_seconds, output ready);
endinterface

interface dtas_rsp_if ();
   logic valid;
   logic ready;
   logic [dtas_pkg::YEAR_W-1:0]   year_out;
   logic [dtas_pkg::MONTH_W-1:0]  month_out;
   logic [dtas_pkg::DAY_W-1:0]    day_out;
   logic [dtas_pkg::HOUR_W-1:0]   hour_out;
   logic [dtas_pkg::MINUTE_W-1:0] minute_out;
   logic [dtas_pkg::SECOND_W-1:0] second_out;

   modport source (output valid, year_out, month_out, day_out, hour_out, minute_out,
                   second_out, input ready);
   modport sink (input valid, year_out, month_out, day_out, hour_out, minute_out,
                 second_out, output ready);
endinterface

>>> design/datetime_add_seconds_core.sv
// top level of the datetime add seconds core
`timescale 1ns / 1ps

// Adds a signed number of seconds to a Gregorian date and time. Second, minute
// and hour are floor-normalized one after the other by a shared divider (60,
// 60, 24); the day carry that is left is then walked one calendar day per
// cycle with the Gregorian leap rule, years wrapping modulo 16384. An item with
// a nonzero offset passes three times in a row through the divider's two-stage
// reciprocal multiply, then through the day walk, to the response register. A
// zero offset skips the divider and returns the fields unchanged. The front
// stage accepts a word whenever the QUEUE_DEPTH-word queue has room, so up to
// QUEUE_DEPTH + 2 words can be in flight, and the response register lets the
// back part finish the next word while a response waits.

module datetime_add_seconds_core #(
   parameter int DELTA_WIDTH = dtas_pkg::DELTA_WIDTH_DEF,
   parameter int QUEUE_DEPTH = dtas_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   dtas_req_if.sink     req_if,
   dtas_rsp_if.source   rsp_if
);

   localparam int DATE_W  = $bits(dtas_pkg::dtas_date_type);
   localparam int ENTRY_W = DATE_W + DELTA_WIDTH + 2;

   // front to queue
   logic                    push;
   logic                    queue_full;
   dtas_pkg::dtas_date_type front_date;
   logic [DELTA_WIDTH:0]    front_sum;
   logic                    front_zero;
   logic [ENTRY_W-1:0]      push_word;

   // queue to back
   logic                    pop;
   logic                    queue_avail;
   logic [ENTRY_W-1:0]      pop_word;
   dtas_pkg::dtas_date_type entry_date;
   logic [DELTA_WIDTH:0]    entry_sum;
   logic                    entry_zero;

   // back to divider
   dtas_pkg::dtas_div_ctl_type div_ctl;
   logic [DELTA_WIDTH:0]       div_operand;
   logic                       div_done;
   logic [DELTA_WIDTH:0]       div_quo;
   logic [5:0]                 div_rem;

   dtas_pkg::dtas_result_type  rsp_data;

   // accept, pre-add the seconds, flag a zero offset
   dtas_front #(.DELTA_WIDTH(DELTA_WIDTH)) u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .date       (front_date),
      .sum        (front_sum),
      .zero       (front_zero)
   );

   assign push_word = {front_zero, front_date, front_sum};

   // decouples acceptance from the multi-cycle back part
   dtas_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (pop),
      .pop_word  (pop_word),
      .avail     (queue_avail)
   );

   assign {entry_zero, entry_date, entry_sum} = pop_word;

   // normalization sequencer, day walk and response register
   dtas_back #(.DELTA_WIDTH(DELTA_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_avail (queue_avail),
      .entry_date  (entry_date),
      .entry_sum   (entry_sum),
      .entry_zero  (entry_zero),
      .entry_pop   (pop),
      .div_ctl     (div_ctl),
      .div_operand (div_operand),
      .div_done    (div_done),
      .div_quo     (div_quo),
      .div_rem     (div_rem),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_data    (rsp_data)
   );

   // shared floor divider, reciprocal multiply then one correction
   dtas_div #(.DELTA_WIDTH(DELTA_WIDTH)) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .operand (div_operand),
      .done    (div_done),
      .quo     (div_quo),
      .rem     (div_rem)
   );

   // response word
   assign rsp_if.year_out   = rsp_data.year;
   assign rsp_if.month_out  = rsp_data.month;
   assign rsp_if.day_out    = rsp_data.day;
   assign rsp_if.hour_out   = rsp_data.hour;
   assign rsp_if.minute_out = rsp_data.minute;
   assign rsp_if.second_out = rsp_data.second;

endmodule

>>> design/dtas_fifo.sv
// short word queue between the front and back parts
`timescale 1ns / 1ps

module dtas_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dtas_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_word,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_word,
   output logic             avail
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign avail    = (count_ff != '0);
   assign pop_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> design/dtas_front.sv
// front part: takes request words, pre-adds the seconds and flags a zero offset
`timescale 1ns / 1ps

module dtas_front #(
   parameter int DELTA_WIDTH = dtas_pkg::DELTA_WIDTH_DEF
) (
   dtas_req_if.sink                 req_if,
   input  logic                     queue_full,
   output logic                     push,
   output dtas_pkg::dtas_date_type  date,
   output logic [DELTA_WIDTH:0]     sum,
   output logic                     zero
);

   localparam int SUM_W = DELTA_WIDTH + 1;

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   always_comb begin
      date.year   = req_if.year_in;
      date.month  = req_if.month_in;
      date.day    = req_if.day_in;
      date.hour   = req_if.hour_in;
      date.minute = req_if.minute_in;
      sum  = {req_if.delta_seconds[DELTA_WIDTH-1], req_if.delta_seconds}
           + {{(SUM_W - dtas_pkg::SECOND_W){1'b0}}, req_if.second_in};
      zero = (req_if.delta_seconds == '0);
   end

endmodule

>>> design/dtas_div.sv
// floor divider by 60 or 24, reciprocal multiply then one correction
`timescale 1ns / 1ps

module dtas_div #(
   parameter int DELTA_WIDTH = dtas_pkg::DELTA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dtas_pkg::dtas_div_ctl_type ctl,
   input  logic [DELTA_WIDTH:0]       operand,
   output logic                       done,
   output logic [DELTA_WIDTH:0]       quo,
   output logic [5:0]                 rem
);

   localparam int DW = DELTA_WIDTH;
   localparam logic [DW-1:0] RECIP_60 = DW'((64'd1 << DW) / 64'd60);
   localparam logic [DW-1:0] RECIP_24 = DW'((64'd1 << DW) / 64'd24);

   // stage a: magnitude and quotient estimate
   logic          valid_a_ff;
   logic          neg_a_ff, neg_a_in;
   logic          by24_a_ff;
   logic [DW-1:0] mag_a_ff, mag_a_in;
   logic [DW-1:0] qest_a_ff, qest_a_in;
   logic [2*DW-1:0] prod;

   // stage b: corrected result
   logic          done_ff;
   logic [DW:0]   quo_ff, quo_in;
   logic [5:0]    rem_ff, rem_in;

   logic [DW+5:0] q_ext, mag_ext, qd, r_full;
   logic [6:0]    dsor, r7, r_fix;
   logic [DW-1:0] q_fix;

   always_comb begin
      neg_a_in  = operand[DW];
      mag_a_in  = neg_a_in ? ~operand[DW-1:0] : operand[DW-1:0];
      prod      = {{DW{1'b0}}, mag_a_in} * {{DW{1'b0}}, (ctl.by_24 ? RECIP_24 : RECIP_60)};
      qest_a_in = prod[2*DW-1:DW];
   end

   always_comb begin
      q_ext   = {6'b0, qest_a_ff};
      mag_ext = {6'b0, mag_a_ff};
      qd      = by24_a_ff ? ((q_ext << 5) - (q_ext << 3)) : ((q_ext << 6) - (q_ext << 2));
      r_full  = mag_ext - qd;
      r7      = r_full[6:0];
      dsor    = by24_a_ff ? dtas_pkg::DIVISOR_24 : dtas_pkg::DIVISOR_60;
      if (r7 >= dsor) begin
         q_fix = qest_a_ff + DW'(1);
         r_fix = r7 - dsor;
      end else begin
         q_fix = qest_a_ff;
         r_fix = r7;
      end
      // negative operand went in as its complement
      if (neg_a_ff) begin
         quo_in = ~{1'b0, q_fix};
         rem_in = dsor[5:0] - 6'd1 - r_fix[5:0];
      end else begin
         quo_in = {1'b0, q_fix};
         rem_in = r_fix[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         valid_a_ff <= ctl.start;
         done_ff    <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         neg_a_ff  <= neg_a_in;
         by24_a_ff <= ctl.by_24;
         mag_a_ff  <= mag_a_in;
         qest_a_ff <= qest_a_in;
      end
      if (valid_a_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

>>> design/dtas_back.sv
// back part: sequences the three divisions, walks the day carry, holds the result
`timescale 1ns / 1ps

module dtas_back #(
   parameter int DELTA_WIDTH = dtas_pkg::DELTA_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        entry_avail,
   input  dtas_pkg::dtas_date_type     entry_date,
   input  logic [DELTA_WIDTH:0]        entry_sum,
   input  logic                        entry_zero,
   output logic                        entry_pop,
   output dtas_pkg::dtas_div_ctl_type  div_ctl,
   output logic [DELTA_WIDTH:0]        div_operand,
   input  logic                        div_done,
   input  logic [DELTA_WIDTH:0]        div_quo,
   input  logic [5:0]                  div_rem,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dtas_pkg::dtas_result_type   rsp_data
);

   localparam int SUM_W   = DELTA_WIDTH + 1;
   localparam int CARRY_W = DELTA_WIDTH - 14;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV_SEC  = 3'd1;
   localparam logic [2:0] ST_DIV_MIN  = 3'd2;
   localparam logic [2:0] ST_DIV_HOUR = 3'd3;
   localparam logic [2:0] ST_WALK     = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [dtas_pkg::YEAR_W-1:0]   year_ff, year_in;
   logic [dtas_pkg::MONTH_W-1:0]  month_ff, month_in;
   logic [dtas_pkg::DAY_W-1:0]    day_ff, day_in;
   logic [dtas_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [dtas_pkg::MINUTE_W-1:0] minute_ff, minute_in;
   logic [dtas_pkg::SECOND_W-1:0] second_ff, second_in;
   logic [CARRY_W-1:0]            days_ff, days_in;

   logic                      out_valid_ff, out_valid_in;
   dtas_pkg::dtas_result_type out_ff, out_in;

   logic [dtas_pkg::DAY_W-1:0]   dim_cur, dim_prev;
   logic [dtas_pkg::MONTH_W-1:0] prev_month;
   logic [dtas_pkg::YEAR_W-1:0]  prev_year;
   logic                         out_free, days_pos, days_neg;

   always_comb begin
      dim_cur = dtas_pkg::days_of(year_ff, month_ff);
      if (month_ff > dtas_pkg::MONTH_JAN) begin
         prev_month = month_ff - 4'd1;
         prev_year  = year_ff;
      end else begin
         prev_month = dtas_pkg::MONTH_DEC;
         prev_year  = year_ff - 14'd1;
      end
      dim_prev = dtas_pkg::days_of(prev_year, prev_month);
      days_neg = days_ff[CARRY_W-1];
      days_pos = !days_neg && (days_ff != '0);
      out_free = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      days_in      = days_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      entry_pop    = 1'b0;
      div_ctl      = '0;
      div_operand  = entry_sum;

      unique case (state_ff)
         ST_IDLE: begin
            if (entry_avail) begin
               entry_pop = 1'b1;
               year_in   = entry_date.year;
               month_in  = entry_date.month;
               day_in    = entry_date.day;
               hour_in   = entry_date.hour;
               minute_in = entry_date.minute;
               second_in = entry_sum[dtas_pkg::SECOND_W-1:0];
               days_in   = '0;
               if (entry_zero) begin
                  state_in = ST_WALK;
               end else begin
                  div_ctl.start = 1'b1;
                  state_in      = ST_DIV_SEC;
               end
            end
         end
         ST_DIV_SEC: begin
            div_operand = div_quo + {{(SUM_W - dtas_pkg::MINUTE_W){1'b0}}, minute_ff};
            if (div_done) begin
               second_in     = div_rem;
               div_ctl.start = 1'b1;
               state_in      = ST_DIV_MIN;
            end
         end
         ST_DIV_MIN: begin
            div_operand   = div_quo + {{(SUM_W - dtas_pkg::HOUR_W){1'b0}}, hour_ff};
            div_ctl.by_24 = 1'b1;
            if (div_done) begin
               minute_in     = div_rem;
               div_ctl.start = 1'b1;
               state_in      = ST_DIV_HOUR;
            end
         end
         ST_DIV_HOUR: begin
            if (div_done) begin
               hour_in  = div_rem[dtas_pkg::HOUR_W-1:0];
               days_in  = div_quo[CARRY_W-1:0];
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (days_pos) begin
               days_in = days_ff - CARRY_W'(1);
               if (day_ff < dim_cur) begin
                  day_in = day_ff + 5'd1;
               end else begin
                  day_in = dtas_pkg::DAY_FIRST;
                  if (month_ff < dtas_pkg::MONTH_DEC) begin
                     month_in = month_ff + 4'd1;
                  end else begin
                     month_in = dtas_pkg::MONTH_JAN;
                     year_in  = year_ff + 14'd1;
                  end
               end
            end else if (days_neg) begin
               days_in = days_ff + CARRY_W'(1);
               if (day_ff > dtas_pkg::DAY_FIRST) begin
                  day_in = day_ff - 5'd1;
               end else begin
                  month_in = prev_month;
                  year_in  = prev_year;
                  day_in   = dim_prev;
               end
            end else if (out_free) begin
               out_in.year   = year_ff;
               out_in.month  = month_ff;
               out_in.day    = day_ff;
               out_in.hour   = hour_ff;
               out_in.minute = minute_ff;
               out_in.second = second_ff;
               out_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      days_ff   <= days_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> design/dtas_checker.sv
// port checker of the datetime add seconds core and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtas_checker #(
   parameter int QUEUE_DEPTH = dtas_pkg::QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [39:0] rsp_word
);

   localparam int CAP   = QUEUE_DEPTH + 2;
   localparam int CNT_W = $clog2(CAP + 1);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + CNT_W'(req_fire) - CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_HOLDS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_HOLDS(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_word))
   `ASSERT_HOLDS(a_pending_cap, clock, reset, pending_ff <= CNT_W'(CAP))
   `ASSERT_NEVER(a_no_invented, clock, reset, rsp_valid && (pending_ff == '0))

endmodule

bind datetime_add_seconds_core dtas_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dtas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_word  ({rsp_if.year_out, rsp_if.month_out, rsp_if.day_out, rsp_if.hour_out,
                rsp_if.minute_out, rsp_if.second_out})
);

>>> verif/datetime_add_seconds_core_tb.sv
// testbench of the datetime add seconds core: directed table, then random words checked by a predictor
`timescale 1ns / 1ps

module datetime_add_seconds_core_tb;

   import dtas_pkg::*;

   localparam int DW           = DELTA_WIDTH_DEF;
   localparam int RANDOM_WORDS = 1400;
   localparam int PHASE_WORDS  = 50;     // words per idling phase
   localparam int TAIL_CYCLES  = 120;    // longest day walk plus the divider stages
   localparam int YEAR_WRAP    = 16384;
   localparam int DAY_SECONDS  = 86400;
   localparam int MAX_REPORTS  = 10;

   // idling phases of the random part
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_t;

   // one request word as the testbench sees it
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic signed [DW-1:0] delta;
   } dt_word_t;

   // one row of the directed table: stimulus, then the result where it is typed in
   typedef struct {
      int year, month, day, hour, minute, second, delta;
      int typed;
      int want_year, want_month, want_day, want_hour, want_minute, want_second;
   } dir_row_t;

   localparam int DIR_ROWS = 25;

   // columns: year month day hour minute second delta | typed | expected date and time
   dir_row_t dir_table [DIR_ROWS] = '{
      // zero offset passes the fields through untouched, even out of range ones
      '{2024,  6, 15, 12, 30, 45,        0, 1,  2024,  6, 15, 12, 30, 45},
      '{16383, 15, 31, 31, 63, 63,       0, 1, 16383, 15, 31, 31, 63, 63},
      '{0,     0,  0,  0,  0,  0,        0, 1,     0,  0,  0,  0,  0,  0},
      // one second across a year end, and the year wrap both ways
      '{2023, 12, 31, 23, 59, 59,        1, 1,  2024,  1,  1,  0,  0,  0},
      '{0,     1,  1,  0,  0,  0,       -1, 1, 16383, 12, 31, 23, 59, 59},
      '{16383, 12, 31, 23, 59, 59,       1, 1,     0,  1,  1,  0,  0,  0},
      // leap rule: every fourth year, not centuries, but every fourth century
      '{2024,  2, 28, 10,  0,  0,  86400, 1,  2024,  2, 29, 10,  0,  0},
      '{1900,  2, 28, 10,  0,  0,  86400, 1,  1900,  3,  1, 10,  0,  0},
      '{2000,  2, 28, 10,  0,  0,  86400, 1,  2000,  2, 29, 10,  0,  0},
      '{0,     2, 28,  0,  0,  0,  86400, 1,     0,  2, 29,  0,  0,  0},
      '{2100,  3,  1,  5,  6,  7, -86400, 1,  2100,  2, 28,  5,  6,  7},
      // invalid months are 30 days long
      '{2001,  0, 30,  1,  2,  3,  86400, 1,  2001,  1,  1,  1,  2,  3},
      '{2005, 13, 30,  0,  0,  0,  86400, 1,  2006,  1,  1,  0,  0,  0},
      '{2001,  0,  1,  0,  0,  0, -86400, 1,  2000, 12, 31,  0,  0,  0},
      '{2001, 14,  1,  0,  0,  0, -86400, 1,  2001, 13, 30,  0,  0,  0},
      '{2001, 13, 15,  0,  0,  0,  86400, 1,  2001, 13, 16,  0,  0,  0},
      // day zero forward and backward, day past the month end
      '{2023,  3,  0,  8,  0,  0,  86400, 1,  2023,  3,  1,  8,  0,  0},
      '{2023,  3,  0,  8,  0,  0, -86400, 1,  2023,  2, 28,  8,  0,  0},
      '{2023,  4, 31,  0,  0,  0,  86400, 1,  2023,  5,  1,  0,  0,  0},
      // out of range time fields with a nonzero offset, floor on negatives
      '{2023,  1, 31, 31, 63, 63,        1, 0,     0,  0,  0,  0,  0,  0},
      '{1999,  7,  4,  0,  0,  0,      -61, 0,     0,  0,  0,  0,  0,  0},
      // offset extremes, the longest day walks
      '{2000,  1,  1,  0,  0,  0,  8388607, 0,     0,  0,  0,  0,  0,  0},
      '{2000,  1,  1,  0,  0,  0, -8388608, 0,     0,  0,  0,  0,  0,  0},
      '{16383, 12, 31, 0,  0,  0, -8388608, 0,     0,  0,  0,  0,  0,  0},
      '{2023, 12, 31, 23, 59, 59,  8388607, 0,     0,  0,  0,  0,  0,  0}
   };

   logic clock = 1'b0;
   logic reset;

   dtas_req_if #(.DELTA_WIDTH(DW)) req_if ();
   dtas_rsp_if rsp_if ();

   datetime_add_seconds_core #(.DELTA_WIDTH(DW)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // results still owed by the block, oldest first
   dtas_result_type expected_datetimes [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int failures       = 0;

   dtas_result_type got_dt;
   dtas_result_type want_dt;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic bit leap_year(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_length(input int y, input int m);
      case (m)
         MONTH_FEB: return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default: return 30;   // invalid month
      endcase
   endfunction

   // division rounding toward minus infinity
   function automatic longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && (a < 0)) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic dtas_result_type add_seconds_to_date(input dt_word_t w);
      int year;
      int month;
      int day;
      longint hour;
      longint minute;
      longint second;
      longint carry;
      longint days;
      dtas_result_type r;
      year   = int'(w.year);
      month  = int'(w.month);
      day    = int'(w.day);
      hour   = longint'(w.hour);
      minute = longint'(w.minute);
      second = longint'(w.second);
      if (w.delta != 0) begin
         // floor normalize second, minute, hour in turn
         second = second + longint'(w.delta);
         carry  = floor_div(second, 60);
         second = second - carry * 60;
         minute = minute + carry;
         carry  = floor_div(minute, 60);
         minute = minute - carry * 60;
         hour   = hour + carry;
         carry  = floor_div(hour, 24);
         hour   = hour - carry * 24;
         days   = carry;
         // walk the day carry one calendar day at a time
         while (days > 0) begin
            if (day < month_length(year, month)) begin
               day = day + 1;
            end else begin
               day = 1;
               if (month < 12) begin
                  month = month + 1;
               end else begin
                  month = 1;
                  year  = (year + 1) % YEAR_WRAP;
               end
            end
            days = days - 1;
         end
         while (days < 0) begin
            if (day > 1) begin
               day = day - 1;
            end else begin
               if (month > 1) begin
                  month = month - 1;
               end else begin
                  month = 12;
                  year  = (year + YEAR_WRAP - 1) % YEAR_WRAP;
               end
               day = month_length(year, month);
            end
            days = days + 1;
         end
      end
      r.year   = YEAR_W'(year);
      r.month  = MONTH_W'(month);
      r.day    = DAY_W'(day);
      r.hour   = HOUR_W'(hour);
      r.minute = MINUTE_W'(minute);
      r.second = SECOND_W'(second);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // random words: mostly valid dates near carries, some noise
   // ---------------------------------------------------------------

   function automatic dt_word_t random_word();
      dt_word_t w;
      int pick;
      int len;

      // year: anywhere, near the wrap, or on a century
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         w.year = YEAR_W'($urandom_range(0, 2));
      end else if (pick < 10) begin
         w.year = YEAR_W'($urandom_range(YEAR_WRAP - 3, YEAR_WRAP - 1));
      end else if (pick < 25) begin
         w.year = YEAR_W'(100 * $urandom_range(0, 163));
      end else begin
         w.year = YEAR_W'($urandom_range(0, YEAR_WRAP - 1));
      end

      // month: valid mostly, any 4 bit code now and then
      if ($urandom_range(0, 99) < 90) begin
         w.month = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
      end else begin
         w.month = MONTH_W'($urandom_range(0, 15));
      end

      // day: in the month, on its edges, or any 5 bit value
      len  = month_length(int'(w.year), int'(w.month));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         w.day = DAY_W'(len);
      end else if (pick < 35) begin
         w.day = DAY_FIRST;
      end else if (pick < 45) begin
         w.day = DAY_W'($urandom_range(0, 31));
      end else begin
         w.day = DAY_W'($urandom_range(1, len));
      end

      // time of day: random, close to midnight on either side, or out of range
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         w.hour   = HOUR_W'($urandom_range(0, 31));
         w.minute = MINUTE_W'($urandom_range(0, 63));
         w.second = SECOND_W'($urandom_range(0, 63));
      end else if (pick < 25) begin
         w.hour   = HOUR_W'(23);
         w.minute = MINUTE_W'(59);
         w.second = SECOND_W'($urandom_range(50, 59));
      end else if (pick < 40) begin
         w.hour   = '0;
         w.minute = '0;
         w.second = SECOND_W'($urandom_range(0, 9));
      end else begin
         w.hour   = HOUR_W'($urandom_range(0, 23));
         w.minute = MINUTE_W'($urandom_range(0, 59));
         w.second = SECOND_W'($urandom_range(0, 59));
      end

      // offset: mostly short walks, a few over the full range
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         w.delta = '0;
      end else if (pick < 35) begin
         w.delta = DW'($signed($urandom_range(0, 240)) - 120);
      end else if (pick < 65) begin
         w.delta = DW'($signed($urandom_range(0, 4 * DAY_SECONDS)) - 2 * DAY_SECONDS);
      end else if (pick < 85) begin
         w.delta = DW'($signed($urandom_range(0, 80 * DAY_SECONDS)) - 40 * DAY_SECONDS);
      end else if (pick < 93) begin
         w.delta = DW'($urandom);
      end else begin
         case ($urandom_range(0, 5))
            0: w.delta = {1'b0, {(DW-1){1'b1}}};
            1: w.delta = {1'b1, {(DW-1){1'b0}}};
            2: w.delta = DW'(1);
            3: w.delta = '1;
            4: w.delta = DW'(DAY_SECONDS);
            default: w.delta = DW'(-DAY_SECONDS);
         endcase
      end
      return w;
   endfunction

   // ---------------------------------------------------------------
   // request side: drive at the falling edge, accept at the rising edge
   // ---------------------------------------------------------------

   task automatic send_word(input dt_word_t w, input int typed, input dtas_result_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.year_in       = w.year;
      req_if.month_in      = w.month;
      req_if.day_in        = w.day;
      req_if.hour_in       = w.hour;
      req_if.minute_in     = w.minute;
      req_if.second_in     = w.second;
      req_if.delta_seconds = w.delta;
      req_if.valid         = 1'b1;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      // word taken: owe its result
      if (typed != 0) begin
         expected_datetimes.push_back(want);
      end else begin
         expected_datetimes.push_back(add_seconds_to_date(w));
      end
   endtask

   // drop valid and hold off until the block has answered everything
   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_datetimes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_idle_mode(input idle_mode_t mode);
      case (mode)
         IDLE_SENDER: begin
            send_idle_pct  = 85;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 85;
         end
         IDLE_BOTH: begin
            send_idle_pct  = 33;
            recv_stall_pct = 33;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // response side: random stalls, check each word against the oldest result owed
   // ---------------------------------------------------------------

   always @(negedge clock) begin
      rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_dt = {rsp_if.year_out, rsp_if.month_out, rsp_if.day_out,
                   rsp_if.hour_out, rsp_if.minute_out, rsp_if.second_out};
         if (expected_datetimes.size() == 0) begin
            failures = failures + 1;
            if (failures <= MAX_REPORTS) begin
               $display("unexpected word %0d-%0d-%0d %0d:%0d:%0d", got_dt.year,
                        got_dt.month, got_dt.day, got_dt.hour, got_dt.minute,
                        got_dt.second);
            end
         end else begin
            want_dt = expected_datetimes.pop_front();
            if (got_dt.year !== want_dt.year || got_dt.month !== want_dt.month ||
                got_dt.day !== want_dt.day || got_dt.hour !== want_dt.hour ||
                got_dt.minute !== want_dt.minute || got_dt.second !== want_dt.second) begin
               failures = failures + 1;
               if (failures <= MAX_REPORTS) begin
                  $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                           want_dt.year, want_dt.month, want_dt.day, want_dt.hour,
                           want_dt.minute, want_dt.second, got_dt.year, got_dt.month,
                           got_dt.day, got_dt.hour, got_dt.minute, got_dt.second);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      dt_word_t w;
      dtas_result_type want;

      // every input known from time zero
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.year_in       = '0;
      req_if.month_in      = '0;
      req_if.day_in        = '0;
      req_if.hour_in       = '0;
      req_if.minute_in     = '0;
      req_if.second_in     = '0;
      req_if.delta_seconds = '0;
      rsp_if.ready         = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, no idling on either side
      set_idle_mode(IDLE_NONE);
      for (int i = 0; i < DIR_ROWS; i++) begin
         w.year   = YEAR_W'(dir_table[i].year);
         w.month  = MONTH_W'(dir_table[i].month);
         w.day    = DAY_W'(dir_table[i].day);
         w.hour   = HOUR_W'(dir_table[i].hour);
         w.minute = MINUTE_W'(dir_table[i].minute);
         w.second = SECOND_W'(dir_table[i].second);
         w.delta  = DW'(dir_table[i].delta);
         want     = {YEAR_W'(dir_table[i].want_year), MONTH_W'(dir_table[i].want_month),
                     DAY_W'(dir_table[i].want_day), HOUR_W'(dir_table[i].want_hour),
                     MINUTE_W'(dir_table[i].want_minute),
                     SECOND_W'(dir_table[i].want_second)};
         send_word(w, dir_table[i].typed, want);
      end
      hold_until_drained();

      // random words, rotating through the idling phases
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % PHASE_WORDS == 0) begin
            set_idle_mode(idle_mode_t'((n / PHASE_WORDS) % 4));
         end
         // one full stop halfway through: the block must empty out and restart
         if (n == RANDOM_WORDS / 2) begin
            hold_until_drained();
         end
         send_word(random_word(), 0, '0);
      end

      // wait for the last results, then a little longer for stray words
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
